### design/sofd_pkg.sv
// ----------------------------------------------------------------------------
// sofd_pkg
// Shared types and constants for the start-of-frame deframer: parse phases,
// result codes, register indexes, reset values and the word bundles that
// pass between the top level and the parser.
// ----------------------------------------------------------------------------
package sofd_pkg;

	// Parse phases; codes above the payload phase behave as hunt
	typedef enum logic [3:0] {
		PH_HUNT = 4'd0,
		PH_DEST = 4'd1,
		PH_SRC  = 4'd2,
		PH_TYPE = 4'd3,
		PH_SUB  = 4'd4,
		PH_SEQ  = 4'd5,
		PH_LEN  = 4'd6,
		PH_CSUM = 4'd7,
		PH_DATA = 4'd8
	} phase_t;

	// Result kinds
	localparam logic [1:0] KIND_IGNORED = 2'd0;
	localparam logic [1:0] KIND_FRAMING = 2'd1;
	localparam logic [1:0] KIND_PAYLOAD = 2'd2;
	localparam logic [1:0] KIND_TICK    = 2'd3;

	// Frame status codes
	localparam logic [2:0] ST_NONE    = 3'd0;
	localparam logic [2:0] ST_GOOD    = 3'd1;
	localparam logic [2:0] ST_BAD_SUM = 3'd2;
	localparam logic [2:0] ST_LEN_REJ = 3'd3;
	localparam logic [2:0] ST_TIMEOUT = 3'd4;

	// Input word kinds
	localparam logic FUNC_BYTE = 1'b0;
	localparam logic FUNC_TICK = 1'b1;

	// Register indexes
	localparam int unsigned CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] CFG_START   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_PAY = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT = 2'd2;
	localparam int unsigned CFG_DATA_W = 16;

	// Register reset values
	localparam logic [7:0]  START_BYTE_RST  = 8'd239;
	localparam logic [7:0]  MAX_PAYLOAD_RST = 8'd64;
	localparam logic [15:0] TIMEOUT_RST     = 16'd100;

	// Last byte position of a four-byte address
	localparam logic [7:0] ADDR_LAST = 8'd3;

	typedef struct packed {
		logic [7:0]  start_byte;
		logic [7:0]  max_payload;
		logic [15:0] rx_timeout_ticks;
	} cfg_t;

	typedef struct packed {
		logic [1:0]  result_kind;
		logic [7:0]  payload_byte;
		logic [7:0]  payload_index;
		logic [2:0]  frame_status;
		logic [31:0] dest_addr;
		logic [31:0] source_addr;
		logic [7:0]  frame_type;
		logic [7:0]  frame_subtype;
		logic [7:0]  sequence_res;
		logic [7:0]  payload_len;
		logic [7:0]  checksum_rx;
	} res_t;

endpackage

### design/sofd_parser.sv
// ----------------------------------------------------------------------------
// sofd_parser
// Frame parse state and the single-pass update for one word: phase walk,
// header capture, running XOR, receive timer and the result word.
// ----------------------------------------------------------------------------
module sofd_parser (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                step,
	input  logic                func,
	input  logic [7:0]          rx_byte,
	input  sofd_pkg::cfg_t      cfg,
	output sofd_pkg::res_t      res
);

	sofd_pkg::phase_t phase_q, phase_d;
	logic [7:0]  cnt_q, cnt_d;
	logic [7:0]  xor_q, xor_d;
	logic [31:0] dest_q, dest_d;
	logic [31:0] src_q, src_d;
	logic [7:0]  type_q, type_d;
	logic [7:0]  sub_q, sub_d;
	logic [7:0]  seq_q, seq_d;
	logic [7:0]  len_q, len_d;
	logic [7:0]  csum_q, csum_d;
	logic [15:0] tmo_q, tmo_d;
	logic        timer_q, timer_d;

	logic [7:0]  cnt_inc;
	logic [15:0] tmo_inc;
	logic        timed_out;
	logic        addr_done;
	logic        data_last;
	logic        len_bad;
	logic        is_start;
	logic [1:0]  kind;
	logic [2:0]  status;
	logic [7:0]  pbyte;
	logic [7:0]  pidx;
	logic        show;

	// Shared increments and compares
	assign cnt_inc   = cnt_q + 8'd1;
	assign tmo_inc   = (tmo_q == 16'hFFFF) ? tmo_q : tmo_q + 16'd1;
	assign timed_out = (tmo_inc >= cfg.rx_timeout_ticks);
	assign addr_done = (cnt_q >= sofd_pkg::ADDR_LAST);
	assign data_last = (cnt_inc == len_q);
	assign len_bad   = (rx_byte > cfg.max_payload);
	assign is_start  = (rx_byte == cfg.start_byte);

	// Next phase
	always_comb begin
		phase_d = phase_q;
		if (func == sofd_pkg::FUNC_TICK) begin
			if (timer_q && timed_out) begin
				phase_d = sofd_pkg::PH_HUNT;
			end
		end else begin
			case (phase_q)
				sofd_pkg::PH_DEST: if (addr_done) phase_d = sofd_pkg::PH_SRC;
				sofd_pkg::PH_SRC:  if (addr_done) phase_d = sofd_pkg::PH_TYPE;
				sofd_pkg::PH_TYPE: phase_d = sofd_pkg::PH_SUB;
				sofd_pkg::PH_SUB:  phase_d = sofd_pkg::PH_SEQ;
				sofd_pkg::PH_SEQ:  phase_d = sofd_pkg::PH_LEN;
				sofd_pkg::PH_LEN: begin
					phase_d = len_bad ? sofd_pkg::PH_HUNT : sofd_pkg::PH_CSUM;
				end
				sofd_pkg::PH_CSUM: begin
					phase_d = (len_q != 8'd0) ? sofd_pkg::PH_DATA : sofd_pkg::PH_HUNT;
				end
				sofd_pkg::PH_DATA: if (data_last) phase_d = sofd_pkg::PH_HUNT;
				default: begin
					phase_d = is_start ? sofd_pkg::PH_DEST : sofd_pkg::PH_HUNT;
				end
			endcase
		end
	end

	// Datapath and result for the current word
	always_comb begin
		cnt_d   = cnt_q;
		xor_d   = xor_q;
		dest_d  = dest_q;
		src_d   = src_q;
		type_d  = type_q;
		sub_d   = sub_q;
		seq_d   = seq_q;
		len_d   = len_q;
		csum_d  = csum_q;
		tmo_d   = tmo_q;
		timer_d = timer_q;
		kind    = sofd_pkg::KIND_FRAMING;
		status  = sofd_pkg::ST_NONE;
		pbyte   = 8'd0;
		pidx    = 8'd0;
		if (func == sofd_pkg::FUNC_TICK) begin
			kind = sofd_pkg::KIND_TICK;
			if (timer_q) begin
				tmo_d = tmo_inc;
				if (timed_out) begin
					timer_d = 1'b0;
					status  = sofd_pkg::ST_TIMEOUT;
				end
			end
		end else begin
			case (phase_q)
				sofd_pkg::PH_DEST: begin
					dest_d = {dest_q[23:0], rx_byte};
					xor_d  = xor_q ^ rx_byte;
					cnt_d  = addr_done ? 8'd0 : cnt_inc;
				end
				sofd_pkg::PH_SRC: begin
					src_d = {src_q[23:0], rx_byte};
					xor_d = xor_q ^ rx_byte;
					cnt_d = addr_done ? 8'd0 : cnt_inc;
				end
				sofd_pkg::PH_TYPE: begin
					type_d = rx_byte;
					xor_d  = xor_q ^ rx_byte;
				end
				sofd_pkg::PH_SUB: begin
					sub_d = rx_byte;
					xor_d = xor_q ^ rx_byte;
				end
				sofd_pkg::PH_SEQ: begin
					seq_d = rx_byte;
					xor_d = xor_q ^ rx_byte;
				end
				sofd_pkg::PH_LEN: begin
					len_d = rx_byte;
					xor_d = xor_q ^ rx_byte;
					if (len_bad) begin
						timer_d = 1'b0;
						status  = sofd_pkg::ST_LEN_REJ;
					end
				end
				sofd_pkg::PH_CSUM: begin
					csum_d = rx_byte;
					if (len_q != 8'd0) begin
						cnt_d = 8'd0;
					end else begin
						// Empty payload: frame ends on the checksum byte
						timer_d = 1'b0;
						status  = (xor_q == rx_byte) ? sofd_pkg::ST_GOOD
						                             : sofd_pkg::ST_BAD_SUM;
					end
				end
				sofd_pkg::PH_DATA: begin
					xor_d = xor_q ^ rx_byte;
					cnt_d = cnt_inc;
					kind  = sofd_pkg::KIND_PAYLOAD;
					pbyte = rx_byte;
					pidx  = cnt_q;
					if (data_last) begin
						timer_d = 1'b0;
						status  = ((xor_q ^ rx_byte) == csum_q) ? sofd_pkg::ST_GOOD
						                                        : sofd_pkg::ST_BAD_SUM;
					end
				end
				default: begin
					if (is_start) begin
						// Start byte: clear holds, seed checksum, restart timer
						dest_d  = 32'd0;
						src_d   = 32'd0;
						type_d  = 8'd0;
						sub_d   = 8'd0;
						seq_d   = 8'd0;
						len_d   = 8'd0;
						csum_d  = 8'd0;
						xor_d   = rx_byte;
						cnt_d   = 8'd0;
						tmo_d   = 16'd0;
						timer_d = 1'b1;
					end else begin
						kind = sofd_pkg::KIND_IGNORED;
					end
				end
			endcase
		end
	end

	// Build the result word; holds show only with a frame status
	assign show = (status != sofd_pkg::ST_NONE);

	always_comb begin
		res.result_kind   = kind;
		res.payload_byte  = pbyte;
		res.payload_index = pidx;
		res.frame_status  = status;
		res.dest_addr     = show ? dest_d : 32'd0;
		res.source_addr   = show ? src_d  : 32'd0;
		res.frame_type    = show ? type_d : 8'd0;
		res.frame_subtype = show ? sub_d  : 8'd0;
		res.sequence_res  = show ? seq_d  : 8'd0;
		res.payload_len   = show ? len_d  : 8'd0;
		res.checksum_rx   = show ? csum_d : 8'd0;
	end

	// Commit state when the word moves to the output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= sofd_pkg::PH_HUNT;
			cnt_q   <= 8'd0;
			xor_q   <= 8'd0;
			dest_q  <= 32'd0;
			src_q   <= 32'd0;
			type_q  <= 8'd0;
			sub_q   <= 8'd0;
			seq_q   <= 8'd0;
			len_q   <= 8'd0;
			csum_q  <= 8'd0;
			tmo_q   <= 16'd0;
			timer_q <= 1'b0;
		end else if (step) begin
			phase_q <= phase_d;
			cnt_q   <= cnt_d;
			xor_q   <= xor_d;
			dest_q  <= dest_d;
			src_q   <= src_d;
			type_q  <= type_d;
			sub_q   <= sub_d;
			seq_q   <= seq_d;
			len_q   <= len_d;
			csum_q  <= csum_d;
			tmo_q   <= tmo_d;
			timer_q <= timer_d;
		end
	end

endmodule

### design/sof_frame_deframer_xor_check.sv
// ----------------------------------------------------------------------------
// sof_frame_deframer_xor_check
// Receive deframer with start byte, length field and XOR checksum.
//
// Input channel (in_valid/in_ready): one word per byte or timer tick; func
// selects which, rx_byte carries the received byte.
// Output channel (out_valid/out_ready): exactly one result word per input
// word, in order: kind, streamed payload byte with its index, and at frame
// end the status together with the captured header fields.
// Configuration: cfg_we writes cfg_wdata to register cfg_index (0 start
// byte, 1 largest length, 2 timeout ticks); write only while idle.
// Path: a word accepted into the input register is parsed combinationally and
// its result is registered in the output register once that register is free
// or being read. Throughput: one word per cycle while the sink keeps out_ready
// high, set by the combinational parser update between the two registers.
// Reset: parser returns to hunt, timer stops, registers take their defaults.
// Stall: the output register holds its word while out_ready is low; one more
// word waits in the input register, after which in_ready drops.
// ----------------------------------------------------------------------------
module sof_frame_deframer_xor_check (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic                                func,
	input  logic [7:0]                          rx_byte,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [1:0]                          result_kind,
	output logic [7:0]                          payload_byte,
	output logic [7:0]                          payload_index,
	output logic [2:0]                          frame_status,
	output logic [31:0]                         dest_addr,
	output logic [31:0]                         source_addr,
	output logic [7:0]                          frame_type,
	output logic [7:0]                          frame_subtype,
	output logic [7:0]                          sequence_res,
	output logic [7:0]                          payload_len,
	output logic [7:0]                          checksum_rx,
	input  logic                                cfg_we,
	input  logic [sofd_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [sofd_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

	sofd_pkg::cfg_t cfg_q;
	logic           valid_s1;
	logic           func_s1;
	logic [7:0]     byte_s1;
	logic           advance;
	logic           out_valid_q;
	sofd_pkg::res_t res_d;
	sofd_pkg::res_t res_q;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.start_byte       <= sofd_pkg::START_BYTE_RST;
			cfg_q.max_payload      <= sofd_pkg::MAX_PAYLOAD_RST;
			cfg_q.rx_timeout_ticks <= sofd_pkg::TIMEOUT_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				sofd_pkg::CFG_START:   cfg_q.start_byte       <= cfg_wdata[7:0];
				sofd_pkg::CFG_MAX_PAY: cfg_q.max_payload      <= cfg_wdata[7:0];
				sofd_pkg::CFG_TIMEOUT: cfg_q.rx_timeout_ticks <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// Move a word from the input register when the output register frees up
	assign advance  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			func_s1 <= func;
			byte_s1 <= rx_byte;
		end
	end

	sofd_parser u_parser (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (advance),
		.func    (func_s1),
		.rx_byte (byte_s1),
		.cfg     (cfg_q),
		.res     (res_d)
	);

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= res_d;
		end
	end

	assign out_valid     = out_valid_q;
	assign result_kind   = res_q.result_kind;
	assign payload_byte  = res_q.payload_byte;
	assign payload_index = res_q.payload_index;
	assign frame_status  = res_q.frame_status;
	assign dest_addr     = res_q.dest_addr;
	assign source_addr   = res_q.source_addr;
	assign frame_type    = res_q.frame_type;
	assign frame_subtype = res_q.frame_subtype;
	assign sequence_res  = res_q.sequence_res;
	assign payload_len   = res_q.payload_len;
	assign checksum_rx   = res_q.checksum_rx;

	// Input back-pressure only when both registers hold a word and the sink stalls
	assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> (valid_s1 && out_valid_q && !out_ready))
		else $error("in_ready low without a full pipeline and a stalled sink");

	// A rejected length is reported on the length byte itself
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && frame_status == sofd_pkg::ST_LEN_REJ)
		|-> (result_kind == sofd_pkg::KIND_FRAMING && checksum_rx == 8'd0))
		else $error("length reject reported on wrong word kind");

	// A timeout is only ever reported on a tick
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && frame_status == sofd_pkg::ST_TIMEOUT)
		|-> (result_kind == sofd_pkg::KIND_TICK))
		else $error("timeout reported on a received byte");

	// Payload fields stay zero outside payload words
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && result_kind != sofd_pkg::KIND_PAYLOAD)
		|-> (payload_byte == 8'd0 && payload_index == 8'd0))
		else $error("payload fields set on a non-payload word");

endmodule

### tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the start-of-frame deframer. A cycle-free model of
// the parser predicts one result word per accepted input word; a monitor
// compares every result against the oldest prediction. Directed frames cover
// the reset settings, zero length, length reject, checksum error and timer
// expiry. Random frames, broken frames and noise then run under three idle
// patterns and several register settings, the extremes among them.
// ----------------------------------------------------------------------------
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	logic                 clk;
	logic                 arst_n;
	logic                 in_valid;
	logic                 in_ready;
	logic                 func;
	logic [7:0]           rx_byte;
	logic                 out_valid;
	logic                 out_ready;
	logic [1:0]           result_kind;
	logic [7:0]           payload_byte;
	logic [7:0]           payload_index;
	logic [2:0]           frame_status;
	logic [31:0]          dest_addr;
	logic [31:0]          source_addr;
	logic [7:0]           frame_type;
	logic [7:0]           frame_subtype;
	logic [7:0]           sequence_res;
	logic [7:0]           payload_len;
	logic [7:0]           checksum_rx;
	logic                 cfg_we;
	logic [sofd_pkg::CFG_IDX_W-1:0]  cfg_index;
	logic [sofd_pkg::CFG_DATA_W-1:0] cfg_wdata;

	// Parser model state and its copy of the registers
	sofd_pkg::phase_t rx_phase;
	logic [7:0]  rx_count;
	logic [7:0]  rx_xor;
	logic [31:0] hold_dest;
	logic [31:0] hold_src;
	logic [7:0]  hold_type;
	logic [7:0]  hold_sub;
	logic [7:0]  hold_seq;
	logic [7:0]  hold_len;
	logic [7:0]  hold_sum;
	logic [15:0] tick_count;
	logic        timer_on;
	logic [7:0]  cur_start;
	logic [7:0]  cur_max;
	logic [15:0] cur_timeout;

	sofd_pkg::res_t expected_results[$];
	int   send_idle_pct;
	int   recv_idle_pct;
	int   parsed_words;
	int   checked_words;
	int   fail_count;
	int   status_seen[8];

	sof_frame_deframer_xor_check uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.func          (func),
		.rx_byte       (rx_byte),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.result_kind   (result_kind),
		.payload_byte  (payload_byte),
		.payload_index (payload_index),
		.frame_status  (frame_status),
		.dest_addr     (dest_addr),
		.source_addr   (source_addr),
		.frame_type    (frame_type),
		.frame_subtype (frame_subtype),
		.sequence_res  (sequence_res),
		.payload_len   (payload_len),
		.checksum_rx   (checksum_rx),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_wdata     (cfg_wdata)
	);

	initial clk = 1'b0;
	always #10 clk = ~clk;

	// Build a result word; header holds are shown only with a frame status
	function automatic sofd_pkg::res_t make_result(logic [1:0] kind, logic [7:0] pbyte,
			logic [7:0] pidx, logic [2:0] status);
		sofd_pkg::res_t r;
		r = '0;
		r.result_kind   = kind;
		r.payload_byte  = pbyte;
		r.payload_index = pidx;
		r.frame_status  = status;
		if (status != sofd_pkg::ST_NONE) begin
			r.dest_addr     = hold_dest;
			r.source_addr   = hold_src;
			r.frame_type    = hold_type;
			r.frame_subtype = hold_sub;
			r.sequence_res  = hold_seq;
			r.payload_len   = hold_len;
			r.checksum_rx   = hold_sum;
		end
		return r;
	endfunction

	// Close the frame: stop the timer, go back to hunting, grade the checksum
	function automatic logic [2:0] close_frame();
		timer_on = 1'b0;
		rx_phase = sofd_pkg::PH_HUNT;
		return (rx_xor == hold_sum) ? sofd_pkg::ST_GOOD : sofd_pkg::ST_BAD_SUM;
	endfunction

	// Advance the parser model by one word and return its result word
	function automatic sofd_pkg::res_t deframe_predict(logic f, logic [7:0] c);
		logic [2:0] status;
		logic [7:0] idx;
		status = sofd_pkg::ST_NONE;
		if (f == sofd_pkg::FUNC_TICK) begin
			if (timer_on) begin
				if (tick_count != 16'hFFFF)
					tick_count = tick_count + 16'd1;
				if (tick_count >= cur_timeout) begin
					timer_on = 1'b0;
					rx_phase = sofd_pkg::PH_HUNT;
					status   = sofd_pkg::ST_TIMEOUT;
				end
			end
			return make_result(sofd_pkg::KIND_TICK, 8'h00, 8'h00, status);
		end
		case (rx_phase)
			sofd_pkg::PH_DEST: begin
				hold_dest = {hold_dest[23:0], c};
				rx_xor    = rx_xor ^ c;
				if (rx_count >= sofd_pkg::ADDR_LAST) begin
					rx_count = 8'd0;
					rx_phase = sofd_pkg::PH_SRC;
				end else begin
					rx_count = rx_count + 8'd1;
				end
			end
			sofd_pkg::PH_SRC: begin
				hold_src = {hold_src[23:0], c};
				rx_xor   = rx_xor ^ c;
				if (rx_count >= sofd_pkg::ADDR_LAST) begin
					rx_count = 8'd0;
					rx_phase = sofd_pkg::PH_TYPE;
				end else begin
					rx_count = rx_count + 8'd1;
				end
			end
			sofd_pkg::PH_TYPE: begin
				hold_type = c;
				rx_xor    = rx_xor ^ c;
				rx_phase  = sofd_pkg::PH_SUB;
			end
			sofd_pkg::PH_SUB: begin
				hold_sub = c;
				rx_xor   = rx_xor ^ c;
				rx_phase = sofd_pkg::PH_SEQ;
			end
			sofd_pkg::PH_SEQ: begin
				hold_seq = c;
				rx_xor   = rx_xor ^ c;
				rx_phase = sofd_pkg::PH_LEN;
			end
			sofd_pkg::PH_LEN: begin
				hold_len = c;
				rx_xor   = rx_xor ^ c;
				if (c > cur_max) begin
					timer_on = 1'b0;
					rx_phase = sofd_pkg::PH_HUNT;
					return make_result(sofd_pkg::KIND_FRAMING, 8'h00, 8'h00,
						sofd_pkg::ST_LEN_REJ);
				end
				rx_phase = sofd_pkg::PH_CSUM;
			end
			sofd_pkg::PH_CSUM: begin
				hold_sum = c;
				if (hold_len != 8'd0) begin
					rx_count = 8'd0;
					rx_phase = sofd_pkg::PH_DATA;
				end else begin
					status = close_frame();
					return make_result(sofd_pkg::KIND_FRAMING, 8'h00, 8'h00, status);
				end
			end
			sofd_pkg::PH_DATA: begin
				idx      = rx_count;
				rx_xor   = rx_xor ^ c;
				rx_count = rx_count + 8'd1;
				if (rx_count == hold_len)
					status = close_frame();
				return make_result(sofd_pkg::KIND_PAYLOAD, c, idx, status);
			end
			default: begin
				rx_phase = sofd_pkg::PH_HUNT;
				if (c != cur_start)
					return make_result(sofd_pkg::KIND_IGNORED, 8'h00, 8'h00,
						sofd_pkg::ST_NONE);
				// start byte: clear the holds and restart the timer
				hold_dest  = '0;
				hold_src   = '0;
				hold_type  = '0;
				hold_sub   = '0;
				hold_seq   = '0;
				hold_len   = '0;
				hold_sum   = '0;
				rx_xor     = c;
				rx_count   = 8'd0;
				tick_count = 16'd0;
				timer_on   = 1'b1;
				rx_phase   = sofd_pkg::PH_DEST;
			end
		endcase
		return make_result(sofd_pkg::KIND_FRAMING, 8'h00, 8'h00, sofd_pkg::ST_NONE);
	endfunction

	task automatic show_result(input string tag, input sofd_pkg::res_t r);
		$display("  %s kind=%0d byte=%h idx=%0d status=%0d dest=%h src=%h",
			tag, r.result_kind, r.payload_byte, r.payload_index, r.frame_status,
			r.dest_addr, r.source_addr);
		$display("  %s type=%h sub=%h seq=%h len=%h sum=%h", tag, r.frame_type,
			r.frame_subtype, r.sequence_res, r.payload_len, r.checksum_rx);
	endtask

	// Send one word, predict its result, then maybe idle the input
	task automatic send_word(input logic f, input logic [7:0] b);
		sofd_pkg::res_t r;
		logic live;
		in_valid <= 1'b1;
		func     <= f;
		rx_byte  <= b;
		do @(posedge clk); while (!in_ready);
		live = timer_on || (f == sofd_pkg::FUNC_BYTE);
		r = deframe_predict(f, b);
		expected_results.push_back(r);
		if (live && r.result_kind != sofd_pkg::KIND_IGNORED)
			parsed_words++;
		if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
		end
	endtask

	// Drop valid and wait until every predicted word has come back
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic [sofd_pkg::CFG_IDX_W-1:0] idx,
			input logic [15:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		case (idx)
			sofd_pkg::CFG_START:   cur_start   = val[7:0];
			sofd_pkg::CFG_MAX_PAY: cur_max     = val[7:0];
			sofd_pkg::CFG_TIMEOUT: cur_timeout = val;
			default: ;
		endcase
	endtask

	task automatic set_config(input logic [7:0] sb, input logic [7:0] mp,
			input logic [15:0] to);
		drain();
		write_reg(sofd_pkg::CFG_START, {8'h00, sb});
		write_reg(sofd_pkg::CFG_MAX_PAY, {8'h00, mp});
		write_reg(sofd_pkg::CFG_TIMEOUT, to);
	endtask

	// Send a frame with random payload; keep limits the bytes sent, and ticks
	// are mixed in at tick_pct percent
	task automatic send_frame(input logic [31:0] dest, input logic [31:0] src,
			input logic [7:0] typ, input logic [7:0] sub, input logic [7:0] seq,
			input logic [7:0] len, input bit bad_sum, input int keep,
			input int tick_pct);
		logic [7:0] frame_bytes[$];
		logic [7:0] body[$];
		logic [7:0] sum;
		int i;
		frame_bytes = {cur_start, dest[31:24], dest[23:16], dest[15:8], dest[7:0],
			src[31:24], src[23:16], src[15:8], src[7:0], typ, sub, seq, len};
		sum = 8'h00;
		foreach (frame_bytes[k])
			sum = sum ^ frame_bytes[k];
		for (i = 0; i < len; i++) begin
			body.push_back(8'($urandom_range(255)));
			sum = sum ^ body[i];
		end
		if (bad_sum)
			sum = sum ^ 8'($urandom_range(255, 1));
		frame_bytes.push_back(sum);
		frame_bytes = {frame_bytes, body};
		for (i = 0; i < frame_bytes.size() && i < keep; i++) begin
			if (tick_pct != 0 && $urandom_range(99) < tick_pct)
				send_word(sofd_pkg::FUNC_TICK, 8'($urandom_range(255)));
			send_word(sofd_pkg::FUNC_BYTE, frame_bytes[i]);
		end
	endtask

	// Mostly well-formed frames; the rest is length rejects, cut-off frames
	// left to time out, and noise
	task automatic random_traffic(input int words);
		int stop_at;
		int choice;
		int cap;
		int len;
		stop_at = parsed_words + words;
		while (parsed_words < stop_at) begin
			choice = $urandom_range(99);
			cap = (cur_max < 12) ? cur_max : 12;
			len = ($urandom_range(7) == 0) ? $urandom_range(cur_max, 0)
				: $urandom_range(cap, 0);
			if (choice < 65) begin
				send_frame($urandom, $urandom, 8'($urandom_range(255)),
					8'($urandom_range(255)), 8'($urandom_range(255)), 8'(len),
					$urandom_range(4) == 0, 1000, 4);
			end else if (choice < 75) begin
				if (cur_max != 8'hFF)
					send_frame($urandom, $urandom, 8'($urandom_range(255)),
						8'($urandom_range(255)), 8'($urandom_range(255)),
						8'($urandom_range(255, cur_max + 1)), 1'b0, 13, 0);
			end else if (choice < 85) begin
				send_frame($urandom, $urandom, 8'($urandom_range(255)),
					8'($urandom_range(255)), 8'($urandom_range(255)), 8'(len),
					1'b0, $urandom_range(13 + len, 1), 0);
				repeat ((cur_timeout <= 150) ? cur_timeout : 20)
					send_word(sofd_pkg::FUNC_TICK, 8'($urandom_range(255)));
			end else begin
				repeat ($urandom_range(4, 1))
					send_word(1'($urandom_range(1)), 8'($urandom_range(255)));
			end
		end
	endtask

	// Reset settings: noise, idle tick, zero length, length reject, bad sum
	task automatic test_reset_defaults();
		send_word(sofd_pkg::FUNC_BYTE, 8'h00);
		send_word(sofd_pkg::FUNC_TICK, 8'hFF);
		send_frame(32'hFFFF_FFFF, 32'h0000_0000, 8'hFF, 8'h00, 8'hA5, 8'd0, 1'b0,
			1000, 0);
		send_frame(32'h0000_0000, 32'hFFFF_FFFF, 8'h00, 8'hFF, 8'h5A, 8'd65, 1'b0,
			13, 0);
		send_frame(32'h1234_5678, 32'h9ABC_DEF0, 8'h01, 8'h02, 8'h03, 8'd1, 1'b1,
			1000, 0);
	endtask

	// Timer expiry at the shortest limit and with partial address holds
	task automatic test_timer_expiry();
		drain();
		write_reg(sofd_pkg::CFG_TIMEOUT, 16'd1);
		send_word(sofd_pkg::FUNC_BYTE, cur_start);
		send_word(sofd_pkg::FUNC_TICK, 8'h00);
		drain();
		write_reg(sofd_pkg::CFG_TIMEOUT, 16'd3);
		send_word(sofd_pkg::FUNC_BYTE, cur_start);
		send_word(sofd_pkg::FUNC_BYTE, 8'hC3);
		send_word(sofd_pkg::FUNC_BYTE, 8'h3C);
		repeat (4) send_word(sofd_pkg::FUNC_TICK, 8'h55);
	endtask

	task automatic random_phase(input int send_pct, input int recv_pct, input int words);
		drain();
		send_idle_pct = send_pct;
		recv_idle_pct = recv_pct;
		set_config(8'($urandom_range(255)), 8'($urandom_range(64, 8)),
			16'($urandom_range(120, 20)));
		random_traffic(words / 3);
		set_config(8'h00, 8'hFF, 16'hFFFF);
		random_traffic(words / 3);
		set_config(8'hFF, 8'h00, 16'h0001);
		random_traffic(words / 3);
	endtask

	task automatic test_random_sender_idle();
		random_phase(23, 76, 200);
	endtask

	task automatic test_random_receiver_idle();
		random_phase(76, 23, 200);
	endtask

	task automatic test_random_streaming();
		random_phase(0, 0, 200);
	endtask

	// Stall the result port at random
	always @(posedge clk)
		out_ready <= ($urandom_range(99) >= recv_idle_pct);

	// Compare each result word with the oldest prediction
	always @(posedge clk) begin : check_results
		sofd_pkg::res_t got;
		sofd_pkg::res_t want;
		if (arst_n && out_valid && out_ready) begin
			got = {result_kind, payload_byte, payload_index, frame_status, dest_addr,
				source_addr, frame_type, frame_subtype, sequence_res, payload_len,
				checksum_rx};
			checked_words++;
			if (expected_results.size() == 0) begin
				fail_count++;
				if (fail_count <= 10) begin
					$display("unexpected result word at %0t", $realtime);
					show_result("got ", got);
				end
			end else begin
				want = expected_results.pop_front();
				if (got !== want) begin
					fail_count++;
					if (fail_count <= 10) begin
						$display("result word mismatch at %0t", $realtime);
						show_result("want", want);
						show_result("got ", got);
					end
				end else begin
					status_seen[want.frame_status]++;
				end
			end
		end
	end

	initial begin
		arst_n        <= 1'b0;
		in_valid      <= 1'b0;
		func          <= sofd_pkg::FUNC_BYTE;
		rx_byte       <= 8'h00;
		out_ready     <= 1'b0;
		cfg_we        <= 1'b0;
		cfg_index     <= sofd_pkg::CFG_START;
		cfg_wdata     <= '0;
		send_idle_pct = 23;
		recv_idle_pct = 76;
		parsed_words  = 0;
		checked_words = 0;
		fail_count    = 0;
		foreach (status_seen[k])
			status_seen[k] = 0;
		rx_phase    = sofd_pkg::PH_HUNT;
		rx_count    = '0;
		rx_xor      = '0;
		hold_dest   = '0;
		hold_src    = '0;
		hold_type   = '0;
		hold_sub    = '0;
		hold_seq    = '0;
		hold_len    = '0;
		hold_sum    = '0;
		tick_count  = '0;
		timer_on    = 1'b0;
		cur_start   = sofd_pkg::START_BYTE_RST;
		cur_max     = sofd_pkg::MAX_PAYLOAD_RST;
		cur_timeout = sofd_pkg::TIMEOUT_RST;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_defaults();
		test_timer_expiry();
		test_random_sender_idle();
		test_random_receiver_idle();
		test_random_streaming();
		drain();

		// predictions that never came back count as failures
		fail_count += expected_results.size();
		$display("Checked %0d result words: %0d good, %0d bad checksum, %0d length",
			checked_words, status_seen[sofd_pkg::ST_GOOD],
			status_seen[sofd_pkg::ST_BAD_SUM], status_seen[sofd_pkg::ST_LEN_REJ]);
		$display("rejects, %0d timeouts, over three idle patterns and nine settings",
			status_seen[sofd_pkg::ST_TIMEOUT]);
		if (fail_count == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

	// Watchdog for a hung handshake
	initial begin
		#20_000_000;
		$display("RESULT: ERROR");
		$finish;
	end

endmodule

### files.f
design/sofd_pkg.sv
design/sofd_parser.sv
design/sof_frame_deframer_xor_check.sv
tb/testbench.sv
